[src/trtcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trtcm_pkg
// Shared widths, codes and controller/datapath interface types of the meter.
// ----------------------------------------------------------------------------
package trtcm_pkg;

  localparam int WordW    = 64;
  localparam int HalfW    = WordW / 2;
  localparam int LenW     = 16;
  localparam int ColorW   = 2;
  localparam int CfgIdxW  = 3;
  localparam int InDataW  = 80;   // pkt_length + now_ns, already whole bytes
  localparam int OutDataW = 8;    // color padded to one byte
  localparam int DivSteps = WordW;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam int MulSteps = 4;    // 32x32 partial products
  localparam int MulCntW  = $clog2(MulSteps + 1);

  typedef logic [WordW-1:0]  word_t;
  typedef logic [ColorW-1:0] color_t;

  localparam color_t COLOR_GREEN  = 2'd0;
  localparam color_t COLOR_YELLOW = 2'd1;
  localparam color_t COLOR_RED    = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_PEAK_PERIOD  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PEAK_RATE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_COMM_PERIOD  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COMM_RATE    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PEAK_BURST   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_COMM_BURST   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_BYTES  = 3'd6;

  // side: 0 peak bucket, 1 committed bucket
  typedef struct packed {
    logic load;       // capture input transaction
    logic side;
    logic div_start;
    logic mul_start;
    logic fill;       // latch refilled bucket and new stamp
    logic decide;     // color and debit
    logic pass;       // unconfigured meter: green, no update
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic peak_zero;
    logic comm_zero;
    logic div_done;
    logic mul_done;
    logic out_free;
  } status_t;

endpackage

[src/trtcm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trtcm_div
// Radix-2 restoring divider, one quotient bit per cycle, 64 quotient bits.
// ----------------------------------------------------------------------------
module trtcm_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  trtcm_pkg::word_t     dividend,
  input  trtcm_pkg::word_t     divisor,
  output logic                 done,
  output trtcm_pkg::word_t     quotient,
  output trtcm_pkg::word_t     remainder
);

  logic [trtcm_pkg::DivCntW-1:0] cnt;
  logic                          busy;
  trtcm_pkg::word_t              quo;
  trtcm_pkg::word_t              rem;
  logic [trtcm_pkg::WordW:0]     rem_sh;
  logic [trtcm_pkg::WordW:0]     diff;
  logic                          fits;

  assign rem_sh = {rem, quo[trtcm_pkg::WordW-1]};
  assign diff   = rem_sh - {1'b0, divisor};
  assign fits   = ~diff[trtcm_pkg::WordW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == trtcm_pkg::DivCntW'(trtcm_pkg::DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? diff[trtcm_pkg::WordW-1:0] : rem_sh[trtcm_pkg::WordW-1:0];
      quo <= {quo[trtcm_pkg::WordW-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[src/trtcm_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trtcm_dp
// Meter datapath: config, bucket state, divider, partial-product multiplier.
// ----------------------------------------------------------------------------
module trtcm_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [trtcm_pkg::CfgIdxW-1:0]     cfg_index,
  input  trtcm_pkg::word_t                  cfg_data,
  input  logic [trtcm_pkg::InDataW-1:0]     in_data,
  input  logic                              out_ready,
  input  trtcm_pkg::cmd_t                   cmd,
  output trtcm_pkg::status_t                status,
  output logic                              out_valid,
  output trtcm_pkg::color_t                 out_color
);

  // configuration
  trtcm_pkg::word_t peak_period, peak_rate, comm_period, comm_rate;
  trtcm_pkg::word_t peak_burst, comm_burst;
  logic             count_bytes;

  // bucket state
  trtcm_pkg::word_t peak_stamp, comm_stamp, peak_tokens, comm_tokens;

  // per-transaction working registers
  logic [trtcm_pkg::LenW-1:0] len;
  trtcm_pkg::word_t           now;
  trtcm_pkg::word_t           tp, tc, stamp_p_new, stamp_c_new;
  trtcm_pkg::color_t          color;

  // divider
  trtcm_pkg::word_t div_dividend, div_divisor, div_quot, div_rem;
  logic             div_done;

  // multiplier
  trtcm_pkg::word_t                mul_a, mul_b, pp;
  logic [trtcm_pkg::MulCntW-1:0]   mcnt;
  logic                            mbusy, mul_done, pp_valid;
  logic [1:0]                      pp_sh;
  logic [2*trtcm_pkg::WordW-1:0]   acc, pp_wide;
  logic [trtcm_pkg::HalfW-1:0]     a_half, b_half;

  // refill / decide
  trtcm_pkg::word_t           held, burst, tok, charge, prod;
  logic [trtcm_pkg::WordW:0]  sum;
  logic                       prod_sat, red, yellow;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_period <= '0;
      peak_rate   <= '0;
      comm_period <= '0;
      comm_rate   <= '0;
      peak_burst  <= '0;
      comm_burst  <= '0;
      count_bytes <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        trtcm_pkg::CFG_PEAK_PERIOD: peak_period <= cfg_data;
        trtcm_pkg::CFG_PEAK_RATE:   peak_rate   <= cfg_data;
        trtcm_pkg::CFG_COMM_PERIOD: comm_period <= cfg_data;
        trtcm_pkg::CFG_COMM_RATE:   comm_rate   <= cfg_data;
        trtcm_pkg::CFG_PEAK_BURST:  peak_burst  <= cfg_data;
        trtcm_pkg::CFG_COMM_BURST:  comm_burst  <= cfg_data;
        trtcm_pkg::CFG_COUNT_BYTES: count_bytes <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len <= in_data[trtcm_pkg::LenW-1:0];
      now <= in_data[trtcm_pkg::LenW +: trtcm_pkg::WordW];
    end
  end

  // divide elapsed time by the selected period
  assign div_dividend = now - (cmd.side ? comm_stamp : peak_stamp);
  assign div_divisor  = cmd.side ? comm_period : peak_period;

  trtcm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // periods * tokens per period, four registered 32x32 partial products
  assign a_half  = mcnt[0] ? mul_a[trtcm_pkg::WordW-1:trtcm_pkg::HalfW]
                           : mul_a[trtcm_pkg::HalfW-1:0];
  assign b_half  = mcnt[1] ? mul_b[trtcm_pkg::WordW-1:trtcm_pkg::HalfW]
                           : mul_b[trtcm_pkg::HalfW-1:0];
  assign pp_wide = {{trtcm_pkg::WordW{1'b0}}, pp} << (trtcm_pkg::HalfW * pp_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy    <= 1'b0;
      mul_done <= 1'b0;
      mcnt     <= '0;
      pp_valid <= 1'b0;
    end else begin
      mul_done <= 1'b0;
      if (cmd.mul_start) begin
        mbusy    <= 1'b1;
        mcnt     <= '0;
        pp_valid <= 1'b0;
      end else if (mbusy) begin
        mcnt     <= mcnt + 1'b1;
        pp_valid <= (mcnt < trtcm_pkg::MulCntW'(trtcm_pkg::MulSteps));
        if (mcnt == trtcm_pkg::MulCntW'(trtcm_pkg::MulSteps)) begin
          mbusy    <= 1'b0;
          mul_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      // a zero committed period means no elapsed periods
      mul_a <= (cmd.side && status.comm_zero) ? '0 : div_quot;
      mul_b <= cmd.side ? comm_rate : peak_rate;
      acc   <= '0;
    end else if (mbusy) begin
      pp    <= a_half * b_half;
      pp_sh <= 2'(mcnt[0]) + 2'(mcnt[1]);
      if (pp_valid) begin
        acc <= acc + pp_wide;
      end
    end
  end

  // saturating refill, clamp to burst
  assign prod     = acc[trtcm_pkg::WordW-1:0];
  assign prod_sat = |acc[2*trtcm_pkg::WordW-1:trtcm_pkg::WordW];
  assign held     = cmd.side ? comm_tokens : peak_tokens;
  assign burst    = cmd.side ? comm_burst : peak_burst;
  assign sum      = {1'b0, held} + {1'b0, prod};
  assign tok      = (prod_sat || sum[trtcm_pkg::WordW] ||
                     (sum[trtcm_pkg::WordW-1:0] > burst)) ? burst
                                                         : sum[trtcm_pkg::WordW-1:0];

  // stamp + periods*period == now - remainder (mod 2^64)
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      if (cmd.side) begin
        tc          <= tok;
        stamp_c_new <= status.comm_zero ? comm_stamp : now - div_rem;
      end else begin
        tp          <= tok;
        stamp_p_new <= now - div_rem;
      end
    end
  end

  assign charge = count_bytes ? trtcm_pkg::WordW'(len) : trtcm_pkg::WordW'(1);
  assign red    = charge > tp;
  assign yellow = charge > tc;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_stamp  <= '0;
      comm_stamp  <= '0;
      peak_tokens <= '0;
      comm_tokens <= '0;
    end else if (cmd.decide) begin
      peak_stamp  <= stamp_p_new;
      comm_stamp  <= stamp_c_new;
      peak_tokens <= red ? tp : tp - charge;
      comm_tokens <= (red || yellow) ? tc : tc - charge;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass) begin
      color <= trtcm_pkg::COLOR_GREEN;
    end else if (cmd.decide) begin
      color <= red ? trtcm_pkg::COLOR_RED :
               yellow ? trtcm_pkg::COLOR_YELLOW : trtcm_pkg::COLOR_GREEN;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_color <= color;
    end
  end

  assign status.peak_zero = (peak_period == '0);
  assign status.comm_zero = (comm_period == '0);
  assign status.div_done  = div_done;
  assign status.mul_done  = mul_done;
  assign status.out_free  = ~out_valid | out_ready;

endmodule

[src/trtcm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trtcm_ctrl
// Sequencer: peak refill, committed refill, color decision, result hand-off.
// ----------------------------------------------------------------------------
module trtcm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  trtcm_pkg::status_t   status,
  output trtcm_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_SIDE2  = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state, state_next;
  logic       side, side_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    side_next  = side;
    cmd        = '0;
    cmd.side   = side;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          side_next  = 1'b0;
          state_next = S_START;
        end
      end
      S_START: begin
        if (status.peak_zero) begin
          cmd.pass   = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.mul_start = 1'b1;
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        if (status.mul_done) begin
          cmd.fill = 1'b1;
          if (side) begin
            state_next = S_DECIDE;
          end else begin
            side_next  = 1'b1;
            state_next = S_SIDE2;
          end
        end
      end
      S_SIDE2: begin
        // no division when the committed period is zero
        if (status.comm_zero) begin
          cmd.mul_start = 1'b1;
          state_next    = S_MUL;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    status.mul_done |-> state == S_MUL)
    else $error("multiplier finished outside the multiply state");

  a_decide_after_both: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE |-> side && $past(state) == S_MUL)
    else $error("color decided before committed refill");

  a_side2_from_peak: assert property (@(posedge clk) disable iff (rst)
    state == S_SIDE2 |-> side && $past(cmd.fill) && !$past(side))
    else $error("committed pass entered without peak refill");
`endif

endmodule

[src/two_rate_three_color_meter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_rate_three_color_meter_core
// Two-rate three-color policer for a single meter instance.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one packet per transaction (length, ns timestamp);
//   the master stream returns one color per packet, in order.
//   Configuration is a plain write port; write only while no packet is open.
// Operation:
//   Each packet refills the peak bucket, then the committed bucket. Each
//   refill runs the shared radix-2 divider (elapsed / period) and a
//   multiplier built from four 32x32 partial products. The committed refill
//   skips the divider when the committed period is zero, and a packet skips
//   both refills when the peak period is zero (meter unconfigured). The next
//   packet is taken once the color has moved to the output register, so the
//   block takes no new packet before it is through with the last one.
// Reset:
//   Synchronous; config registers clear, both buckets start empty with zero
//   stamps, no result pending.
// Stall:
//   The result sits in an output register. The next packet is accepted while
//   it waits; if a new result is ready before the old one is taken, the block
//   holds it and accepts nothing more until the master side drains.
// ----------------------------------------------------------------------------
module two_rate_three_color_meter_core (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [trtcm_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [trtcm_pkg::WordW-1:0]         cfg_data,
  // packet in
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [trtcm_pkg::InDataW-1:0]       s_tdata,  // pkt_length[15:0], now_ns[79:16]
  // color out
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [trtcm_pkg::OutDataW-1:0]      m_tdata   // color[1:0], zero pad
);

  trtcm_pkg::cmd_t    cmd;
  trtcm_pkg::status_t status;
  trtcm_pkg::color_t  out_color;

  trtcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  trtcm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .out_ready (m_tready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_color (out_color)
  );

  // color in the low bits, rest of the byte zero
  assign m_tdata = {{(trtcm_pkg::OutDataW - trtcm_pkg::ColorW){1'b0}}, out_color};

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking regression for the two-rate three-color meter core.
// A behavioral copy of the meter predicts each packet's color at the moment
// the packet transaction is accepted. A monitor compares every returned
// color, in order, with the oldest prediction. The directed tests cover the
// unconfigured meter, refill saturation, time going backwards, extreme
// periods, a disabled committed refill and packet mode. A back-pressure test
// then fills the block up, and randomized phases run under several meter
// settings.
// ----------------------------------------------------------------------------
module tb_top;
  import trtcm_pkg::*;

  localparam int HoldCycles  = 3000;   // long master-side hold-off
  localparam int DrainLimit  = 50000;  // cycles allowed for outstanding colors
  localparam int TailCycles  = 160;    // idle tail after the final drain
  localparam int RandPhases  = 10;
  localparam int RandPerPhase = 53;

  // Meter settings, one field per config register.
  typedef struct {
    word_t      peak_period;
    word_t      peak_rate;
    word_t      comm_period;
    word_t      comm_rate;
    word_t      peak_burst;
    word_t      comm_burst;
    logic       count_bytes;
  } meter_cfg_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [WordW-1:0]    cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;   // pkt_length[15:0], now_ns[79:16]
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;   // color[1:0], zero pad

  two_rate_three_color_meter_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // --------------------------------------------------------------------------
  // Shared state
  // --------------------------------------------------------------------------
  meter_cfg_t meter;              // settings as last programmed
  word_t      peak_stamp;
  word_t      comm_stamp;
  word_t      peak_tokens;
  word_t      comm_tokens;

  color_t     expected_colors[$];
  int         failures;
  int         packets_sent;
  int         settings_used;
  int         colors_seen[3];
  bit         gaps_on;            // random idling on both sides
  int         hold_off;           // master hold-off, counted down by the sink

  // --------------------------------------------------------------------------
  // Meter prediction
  // --------------------------------------------------------------------------
  function automatic word_t sat_product(input word_t a, input word_t b);
    logic [2*WordW-1:0] p;
    p = {{WordW{1'b0}}, a} * {{WordW{1'b0}}, b};
    return (p[2*WordW-1:WordW] != '0) ? '1 : p[WordW-1:0];
  endfunction

  function automatic word_t sat_sum(input word_t a, input word_t b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW] ? '1 : s[WordW-1:0];
  endfunction

  // Whole elapsed periods refill the bucket; the stamp moves by those periods.
  // Elapsed time wraps modulo 2^64, so a timestamp behind the stamp is huge.
  function automatic word_t refill_bucket(inout word_t stamp, input word_t period,
                                          input word_t rate, input word_t held,
                                          input word_t burst, input word_t now_ns);
    word_t periods;
    word_t tok;
    periods = '0;
    if (period != '0) begin
      periods = (now_ns - stamp) / period;
      stamp   = stamp + periods * period;
    end
    tok = sat_sum(held, sat_product(periods, rate));
    if (tok > burst) tok = burst;
    return tok;
  endfunction

  function automatic color_t meter_color(input logic [LenW-1:0] len, input word_t now_ns);
    word_t tp;
    word_t tc;
    word_t charge;
    if (meter.peak_period == '0) return COLOR_GREEN;  // unconfigured: no update
    tp = refill_bucket(peak_stamp, meter.peak_period, meter.peak_rate, peak_tokens,
                       meter.peak_burst, now_ns);
    tc = refill_bucket(comm_stamp, meter.comm_period, meter.comm_rate, comm_tokens,
                       meter.comm_burst, now_ns);
    charge = meter.count_bytes ? word_t'(len) : word_t'(1);
    if (charge > tp) begin
      // red: nothing debited
      peak_tokens = tp;
      comm_tokens = tc;
      return COLOR_RED;
    end
    if (charge > tc) begin
      // yellow: peak bucket only
      peak_tokens = tp - charge;
      comm_tokens = tc;
      return COLOR_YELLOW;
    end
    peak_tokens = tp - charge;
    comm_tokens = tc - charge;
    return COLOR_GREEN;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("two_rate_three_color_meter_core regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Color sink: drives tready at the falling edge. A pending hold-off keeps
  // tready low until it has counted down; otherwise it idles at random when gaps are on.
  // --------------------------------------------------------------------------
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        m_tready <= 1'b0;
        hold_off--;
      end else begin
        m_tready <= !(gaps_on && ($urandom_range(0, 99) < 31));
      end
    end
  end

  // Monitor: every color transaction is checked against the oldest prediction.
  initial begin
    color_t want;
    color_t got;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = m_tdata[ColorW-1:0];
        if (expected_colors.size() == 0) begin
          $error("color: expected none, actual %0d", got);
          failures++;
        end else begin
          want = expected_colors.pop_front();
          if (got !== want) begin
            $error("color: expected %0d, actual %0d", want, got);
            failures++;
          end
          if (want <= COLOR_RED) colors_seen[want]++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input word_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Only called with the block idle: no packet open, no color outstanding.
  task automatic program_meter(input meter_cfg_t c);
    write_reg(CFG_PEAK_PERIOD, c.peak_period);
    write_reg(CFG_PEAK_RATE,   c.peak_rate);
    write_reg(CFG_COMM_PERIOD, c.comm_period);
    write_reg(CFG_COMM_RATE,   c.comm_rate);
    write_reg(CFG_PEAK_BURST,  c.peak_burst);
    write_reg(CFG_COMM_BURST,  c.comm_burst);
    write_reg(CFG_COUNT_BYTES, word_t'(c.count_bytes));
    @(negedge clk);
    cfg_we <= 1'b0;
    meter = c;
    settings_used++;
  endtask

  // One packet transaction; the color is predicted at the accepting edge.
  // tvalid stays high on return, so the caller either sends again at once
  // or drains.
  task automatic send_packet(input logic [LenW-1:0] len, input word_t now_ns);
    @(negedge clk);
    while (gaps_on && ($urandom_range(0, 99) < 31)) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now_ns, len};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_colors.insert(expected_colors.size(), meter_color(len, now_ns));
    packets_sent++;
  endtask

  // Stop offering packets and wait for every outstanding color.
  task automatic drain_colors();
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_colors.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (expected_colors.size() != 0) begin
      $error("color: expected %0d more transactions, actual none", expected_colors.size());
      failures += expected_colors.size();
      expected_colors.delete();
    end
  endtask

  function automatic meter_cfg_t make_cfg(input word_t pp, input word_t pr, input word_t cp,
                                          input word_t cr, input word_t pb, input word_t cb,
                                          input logic bytes);
    meter_cfg_t c;
    c.peak_period = pp;
    c.peak_rate   = pr;
    c.comm_period = cp;
    c.comm_rate   = cr;
    c.peak_burst  = pb;
    c.comm_burst  = cb;
    c.count_bytes = bytes;
    return c;
  endfunction

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset the peak period is zero: everything is green, no state moves.
  task automatic test_unconfigured();
    send_packet('0, '0);
    send_packet('1, '1);
    send_packet(16'hA5A5, 64'h5A5A_5A5A_5A5A_5A5A);
    send_packet(16'h5A5A, 64'hA5A5_A5A5_A5A5_A5A5);
    drain_colors();
  endtask

  // Huge rates over a huge elapsed time saturate the refill; then a timestamp
  // behind the stamp gives a wrapped elapsed time.
  task automatic test_saturation();
    program_meter(make_cfg(64'd1, '1, 64'd1, '1, '1, '1, 1'b1));
    send_packet('1, '1);
    send_packet('0, '0);
    send_packet(16'd1, 64'h8000_0000_0000_0000);
    drain_colors();
  endtask

  // Longest possible periods: at most one whole period can ever elapse.
  task automatic test_extreme_periods();
    program_meter(make_cfg('1, 64'd7, '1, 64'd7, 64'd100, 64'd50, 1'b1));
    send_packet(16'd3, '1);
    send_packet(16'd8, '0);
    drain_colors();
  endtask

  // Committed refill off: the committed bucket never grows, so any charge
  // above its leftover tokens that the peak bucket covers is yellow.
  task automatic test_committed_off();
    word_t t;
    t = 64'd5_000_000;
    program_meter(make_cfg(64'd1000, 64'd100, 64'd0, 64'd50, 64'd500, 64'd500, 1'b1));
    send_packet(16'd0, t);
    send_packet(16'd100, t);
    send_packet(16'd450, t);
    send_packet(16'd300, t + 64'd1000);
    drain_colors();
  endtask

  // Packet mode charges one token whatever the length, walking through
  // green, yellow and red on tiny buckets.
  task automatic test_packet_mode();
    word_t t;
    t = 64'd9_000_000;
    program_meter(make_cfg(64'd10, 64'd1, 64'd20, 64'd1, 64'd3, 64'd2, 1'b0));
    send_packet('1, t);
    send_packet('0, t);
    send_packet('1, t);
    send_packet(16'd12345, t);
    send_packet(16'd1, t + 64'd20);
    drain_colors();
  endtask

  // The sink holds off for a long stretch while packets keep coming, so the
  // output register fills and the block stops accepting.
  task automatic test_backpressure();
    word_t t;
    t = 64'd20_000_000;
    program_meter(make_cfg(64'd16, 64'd200, 64'd32, 64'd150, 64'd4000, 64'd2000, 1'b1));
    hold_off = HoldCycles;
    for (int i = 0; i < 8; i++) begin
      t = t + word_t'($urandom_range(0, 64));
      send_packet(LenW'($urandom_range(0, 1500)), t);
    end
    drain_colors();
  endtask

  // Randomized phases: each picks meter settings, then a stream of packets
  // with mostly forward time steps. A few steps jump far ahead or backwards.
  task automatic test_random_traffic();
    meter_cfg_t c;
    word_t      t;
    logic [LenW-1:0] len;
    int         pick;
    for (int p = 0; p < RandPhases; p++) begin
      gaps_on = (p != 3);  // one phase runs both sides flat out

      pick = $urandom_range(0, 9);
      c.peak_period = (pick == 0) ? '0 :
                      (pick == 1) ? rand_word() : word_t'($urandom_range(1, 64));
      pick = $urandom_range(0, 19);
      c.comm_period = (pick < 3) ? '0 :
                      (pick < 5) ? rand_word() : word_t'($urandom_range(1, 128));
      c.peak_rate   = ($urandom_range(0, 9) == 0) ? rand_word()
                                                  : word_t'($urandom_range(0, 3000));
      c.comm_rate   = ($urandom_range(0, 9) == 0) ? rand_word()
                                                  : word_t'($urandom_range(0, 2000));
      c.peak_burst  = ($urandom_range(0, 9) == 0) ? '1 : word_t'($urandom_range(0, 40000));
      c.comm_burst  = ($urandom_range(0, 9) == 0) ? '1 : word_t'($urandom_range(0, 20000));
      c.count_bytes = 1'($urandom_range(0, 1));
      program_meter(c);

      t = rand_word();
      for (int i = 0; i < RandPerPhase; i++) begin
        len  = ($urandom_range(0, 9) < 7) ? LenW'($urandom_range(0, 4000))
                                          : LenW'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 85)      t = t + word_t'($urandom_range(0, 200));
        else if (pick < 95) t = t + word_t'($urandom());
        else if (pick < 98) t = t - word_t'($urandom_range(1, 1000));
        else                t = rand_word();
        send_packet(len, t);
      end
      drain_colors();
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    failures      = 0;
    packets_sent  = 0;
    settings_used = 0;
    colors_seen   = '{0, 0, 0};
    gaps_on       = 1'b1;
    hold_off      = 0;
    meter         = make_cfg('0, '0, '0, '0, '0, '0, 1'b0);
    peak_stamp    = '0;
    comm_stamp    = '0;
    peak_tokens   = '0;
    comm_tokens   = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_unconfigured();
    test_saturation();
    test_extreme_periods();
    test_committed_off();
    test_packet_mode();
    test_backpressure();
    test_random_traffic();

    drain_colors();
    repeat (TailCycles) @(posedge clk);

    $display("Covered %0d packets under %0d meter settings, incl. saturation, wrap and stalls.",
             packets_sent, settings_used);
    $display("Colors returned: %0d green, %0d yellow, %0d red.",
             colors_seen[COLOR_GREEN], colors_seen[COLOR_YELLOW], colors_seen[COLOR_RED]);
    if (failures == 0) begin
      $display("two_rate_three_color_meter_core regression: pass");
    end else begin
      $display("two_rate_three_color_meter_core regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/trtcm_pkg.sv
src/trtcm_div.sv
src/trtcm_dp.sv
src/trtcm_ctrl.sv
src/two_rate_three_color_meter_core.sv
tb/tb_top.sv
